[src/eerl_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// eerl_pkg: shared types and constants of the error event rate limiter
// Field widths, register indexes, reset values and the per-code class table.
// ----------------------------------------------------------------------------
package eerl_pkg;

  // field widths
  localparam int CODE_W  = 5;
  localparam int CLASS_W = 4;
  localparam int TIME_W  = 32;
  localparam int COUNT_W = 32;
  localparam int HOLD_W  = 16;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 2;

  // parameter defaults
  localparam int NUM_CODES_DEF       = 32;
  localparam int ESCALATE_PERIOD_DEF = 10;

  // codes 0 to KNOWN_CODES-1 carry a meaning
  localparam int KNOWN_CODES = 18;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_READY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD   = 2'd2;

  // register reset values
  localparam logic [TIME_W-1:0] WINDOW_RST = 32'd60000;
  localparam logic [HOLD_W-1:0] HOLD_RST   = 16'd200;

  // reported classes
  localparam logic [CLASS_W-1:0] CLS_I2C_RD_ERR  = 4'd0;
  localparam logic [CLASS_W-1:0] CLS_I2C_WR_ERR  = 4'd1;
  localparam logic [CLASS_W-1:0] CLS_I2C_RD_WARN = 4'd2;
  localparam logic [CLASS_W-1:0] CLS_I2C_WR_WARN = 4'd3;
  localparam logic [CLASS_W-1:0] CLS_SPI_RD_ERR  = 4'd4;
  localparam logic [CLASS_W-1:0] CLS_SPI_WR_ERR  = 4'd5;
  localparam logic [CLASS_W-1:0] CLS_SPI_RD_WARN = 4'd6;
  localparam logic [CLASS_W-1:0] CLS_SPI_WR_WARN = 4'd7;
  localparam logic [CLASS_W-1:0] CLS_CRC         = 4'd8;
  localparam logic [CLASS_W-1:0] CLS_FW_UPGRADE  = 4'd9;
  localparam logic [CLASS_W-1:0] CLS_ESD_ERR     = 4'd10;
  localparam logic [CLASS_W-1:0] CLS_ESD_WARN    = 4'd11;
  localparam logic [CLASS_W-1:0] CLS_GESTURE     = 4'd12;
  localparam logic [CLASS_W-1:0] CLS_GHOST       = 4'd13;
  localparam logic [CLASS_W-1:0] CLS_HAL_CRASH   = 4'd14;
  localparam logic [CLASS_W-1:0] CLS_SAVE_FULL   = 4'd15;

  // event codes
  localparam logic [CODE_W-1:0] EV_I2C_RD_ERR  = 5'd0;
  localparam logic [CODE_W-1:0] EV_I2C_WR_ERR  = 5'd1;
  localparam logic [CODE_W-1:0] EV_I2C_RD_WARN = 5'd2;
  localparam logic [CODE_W-1:0] EV_I2C_WR_WARN = 5'd3;
  localparam logic [CODE_W-1:0] EV_SPI_RD_ERR  = 5'd4;
  localparam logic [CODE_W-1:0] EV_SPI_WR_ERR  = 5'd5;
  localparam logic [CODE_W-1:0] EV_SPI_RD_WARN = 5'd6;
  localparam logic [CODE_W-1:0] EV_SPI_WR_WARN = 5'd7;
  localparam logic [CODE_W-1:0] EV_CRC         = 5'd8;
  localparam logic [CODE_W-1:0] EV_FW_UPGRADE  = 5'd9;
  localparam logic [CODE_W-1:0] EV_ESD_ERR     = 5'd10;
  localparam logic [CODE_W-1:0] EV_ESD_WARN    = 5'd11;
  localparam logic [CODE_W-1:0] EV_PROBE       = 5'd12;
  localparam logic [CODE_W-1:0] EV_GESTURE     = 5'd13;
  localparam logic [CODE_W-1:0] EV_REQUEST_FW  = 5'd14;
  localparam logic [CODE_W-1:0] EV_GHOST       = 5'd15;
  localparam logic [CODE_W-1:0] EV_HAL_CRASH   = 5'd16;
  localparam logic [CODE_W-1:0] EV_SAVE_FULL   = 5'd17;

  typedef struct packed {
    logic                counted;
    logic                holdoff;
    logic                escalate;
    logic [CLASS_W-1:0]  base_class;
    logic [CLASS_W-1:0]  err_class;
  } code_info_t;

  function automatic code_info_t mk(input logic c, input logic h, input logic e,
                                    input logic [CLASS_W-1:0] b,
                                    input logic [CLASS_W-1:0] x);
    code_info_t r;
    r.counted    = c;
    r.holdoff    = h;
    r.escalate   = e;
    r.base_class = b;
    r.err_class  = x;
    return r;
  endfunction

  // per-code behaviour; unknown codes return all zero
  function automatic code_info_t code_info(input logic [CODE_W-1:0] code);
    code_info_t r;
    unique case (code)
      EV_I2C_RD_ERR:  r = mk(1'b1, 1'b1, 1'b1, CLS_I2C_RD_WARN, CLS_I2C_RD_ERR);
      EV_I2C_WR_ERR:  r = mk(1'b1, 1'b1, 1'b1, CLS_I2C_WR_WARN, CLS_I2C_WR_ERR);
      EV_I2C_RD_WARN: r = mk(1'b1, 1'b1, 1'b0, CLS_I2C_RD_WARN, CLS_I2C_RD_WARN);
      EV_I2C_WR_WARN: r = mk(1'b1, 1'b1, 1'b0, CLS_I2C_WR_WARN, CLS_I2C_WR_WARN);
      EV_SPI_RD_ERR:  r = mk(1'b1, 1'b1, 1'b1, CLS_SPI_RD_WARN, CLS_SPI_RD_ERR);
      EV_SPI_WR_ERR:  r = mk(1'b1, 1'b1, 1'b1, CLS_SPI_WR_WARN, CLS_SPI_WR_ERR);
      EV_SPI_RD_WARN: r = mk(1'b1, 1'b1, 1'b0, CLS_SPI_RD_WARN, CLS_SPI_RD_WARN);
      EV_SPI_WR_WARN: r = mk(1'b1, 1'b1, 1'b0, CLS_SPI_WR_WARN, CLS_SPI_WR_WARN);
      EV_CRC:         r = mk(1'b1, 1'b1, 1'b0, CLS_CRC, CLS_CRC);
      EV_FW_UPGRADE:  r = mk(1'b1, 1'b0, 1'b0, CLS_FW_UPGRADE, CLS_FW_UPGRADE);
      EV_ESD_ERR:     r = mk(1'b1, 1'b0, 1'b1, CLS_ESD_WARN, CLS_ESD_ERR);
      EV_ESD_WARN:    r = mk(1'b1, 1'b0, 1'b0, CLS_ESD_WARN, CLS_ESD_WARN);
      EV_PROBE:       r = mk(1'b0, 1'b0, 1'b0, CLS_ESD_ERR, CLS_ESD_ERR);
      EV_GESTURE:     r = mk(1'b0, 1'b0, 1'b0, CLS_GESTURE, CLS_GESTURE);
      EV_REQUEST_FW:  r = mk(1'b1, 1'b0, 1'b0, CLS_FW_UPGRADE, CLS_FW_UPGRADE);
      EV_GHOST:       r = mk(1'b1, 1'b0, 1'b0, CLS_GHOST, CLS_GHOST);
      EV_HAL_CRASH:   r = mk(1'b1, 1'b1, 1'b0, CLS_HAL_CRASH, CLS_HAL_CRASH);
      EV_SAVE_FULL:   r = mk(1'b1, 1'b1, 1'b0, CLS_SAVE_FULL, CLS_SAVE_FULL);
      default:        r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[src/eerl_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// eerl_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module eerl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[src/error_event_rate_limiter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// error_event_rate_limiter: per-code count and repeat-window report filter
// Counts error events per code in a table RAM, suppresses repeats within a
// window and after a controller reset, and escalates selected codes.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  in        in_valid/in_ready    event_code, now_ms, ms_since_reset
//  out       out_valid/out_ready  notify, notify_code, event_count, dropped
//  cfg       cfg_we               cfg_index, cfg_data
//
//  The table RAM is read at acceptance, the entry is modified and written
//  back as the update stage advances, and the result lands in the output
//  register. A new request is taken every cycle while nothing stalls; a
//  back-to-back request to the same code gets the written word forwarded.
//  Reset clears the per-entry valid bits at once, so no clearing pass.
//  A stalled output register holds the update stage, which holds the input.
// ----------------------------------------------------------------------------
module error_event_rate_limiter #(
  parameter int NUM_CODES       = eerl_pkg::NUM_CODES_DEF,
  parameter int ESCALATE_PERIOD = eerl_pkg::ESCALATE_PERIOD_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // configuration
  input  wire logic                           cfg_we,
  input  wire logic [eerl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [eerl_pkg::CFG_W-1:0]     cfg_data,
  // input requests
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [eerl_pkg::CODE_W-1:0]    event_code,
  input  wire logic [eerl_pkg::TIME_W-1:0]    now_ms,
  input  wire logic [eerl_pkg::TIME_W-1:0]    ms_since_reset,
  // results
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                notify,
  output logic      [eerl_pkg::CLASS_W-1:0]   notify_code,
  output logic      [eerl_pkg::COUNT_W-1:0]   event_count,
  output logic                                dropped
);

  localparam int AW     = $clog2(NUM_CODES);
  localparam int PW     = $clog2(ESCALATE_PERIOD);
  localparam int WORD_W = PW + eerl_pkg::TIME_W + eerl_pkg::COUNT_W;
  localparam logic [PW-1:0] PHASE_LAST = PW'(ESCALATE_PERIOD - 1);

  typedef struct packed {
    logic [PW-1:0]                  phase;
    logic [eerl_pkg::TIME_W-1:0]    last_time;
    logic [eerl_pkg::COUNT_W-1:0]   count;
  } entry_t;

  // configuration registers
  logic                          reporter_ready;
  logic [eerl_pkg::TIME_W-1:0]   repeat_window_ms;
  logic [eerl_pkg::HOLD_W-1:0]   reset_holdoff_ms;

  // update stage
  logic                          s1_valid;
  logic [eerl_pkg::CODE_W-1:0]   s1_code;
  logic [eerl_pkg::TIME_W-1:0]   s1_now;
  logic [eerl_pkg::TIME_W-1:0]   s1_since;
  logic                          s1_ent_valid;
  logic                          s1_fwd;
  entry_t                        s1_fwd_word;

  logic [NUM_CODES-1:0]          entry_valid;
  logic [WORD_W-1:0]             ram_rdata;

  logic                          accept;
  logic                          s1_adv;
  logic                          in_known;
  logic [AW-1:0]                 in_addr;
  logic [AW-1:0]                 s1_addr;

  eerl_pkg::code_info_t          info;
  logic                          s1_known;
  entry_t                        old_word;
  entry_t                        new_word;
  logic [eerl_pkg::TIME_W-1:0]   age;
  logic                          sat;
  logic                          due;
  logic                          held;
  logic                          wr_en;
  logic                          res_notify;
  logic [eerl_pkg::CLASS_W-1:0]  res_code;
  logic [eerl_pkg::COUNT_W-1:0]  res_count;
  logic                          res_dropped;

  // handshake
  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;
  assign accept   = in_valid && in_ready;

  assign in_known = event_code < eerl_pkg::CODE_W'(eerl_pkg::KNOWN_CODES);
  assign in_addr  = AW'(event_code);
  assign s1_addr  = AW'(s1_code);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      reporter_ready   <= 1'b0;
      repeat_window_ms <= eerl_pkg::WINDOW_RST;
      reset_holdoff_ms <= eerl_pkg::HOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        eerl_pkg::REG_READY:  reporter_ready   <= cfg_data[0];
        eerl_pkg::REG_WINDOW: repeat_window_ms <= cfg_data;
        eerl_pkg::REG_HOLD:   reset_holdoff_ms <= cfg_data[eerl_pkg::HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // table of counts, phases and last report times
  eerl_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_CODES)
  ) u_table (
    .clk   (clk),
    .we    (s1_adv && wr_en),
    .waddr (s1_addr),
    .wdata (new_word),
    .re    (accept && in_known),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  // capture the request; forward a write to the same entry
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_code      <= event_code;
      s1_now       <= now_ms;
      s1_since     <= ms_since_reset;
      s1_ent_valid <= in_known && entry_valid[in_addr];
      s1_fwd       <= s1_adv && wr_en && (s1_addr == in_addr);
      s1_fwd_word  <= new_word;
    end
  end

  // mark entries once written
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (s1_adv && wr_en) begin
      entry_valid[s1_addr] <= 1'b1;
    end
  end

  // modify the entry
  always_comb begin
    info     = eerl_pkg::code_info(s1_code);
    s1_known = s1_code < eerl_pkg::CODE_W'(eerl_pkg::KNOWN_CODES);
    if (s1_fwd) begin
      old_word = s1_fwd_word;
    end else if (s1_ent_valid) begin
      old_word = entry_t'(ram_rdata);
    end else begin
      old_word = '0;
    end

    age  = s1_now - old_word.last_time;
    sat  = &old_word.count;
    held = info.holdoff && (s1_since < {{(eerl_pkg::TIME_W - eerl_pkg::HOLD_W){1'b0}},
                                        reset_holdoff_ms});
    due  = ((old_word.count == '0) || (age >= repeat_window_ms)) && !held;

    new_word = old_word;
    if (!sat) begin
      new_word.count = old_word.count + 1'b1;
      new_word.phase = (old_word.phase == PHASE_LAST) ? '0 : old_word.phase + 1'b1;
    end
    if (due) begin
      new_word.last_time = s1_now;
    end

    wr_en       = 1'b0;
    res_notify  = 1'b0;
    res_code    = '0;
    res_count   = '0;
    res_dropped = 1'b0;
    if (!reporter_ready) begin
      res_dropped = 1'b1;
    end else if (s1_known) begin
      if (!info.counted) begin
        res_notify = 1'b1;
        res_code   = info.base_class;
      end else begin
        wr_en     = 1'b1;
        res_count = new_word.count;
        if (due) begin
          res_notify = 1'b1;
          res_code   = (info.escalate && (new_word.phase == '0)) ? info.err_class
                                                                 : info.base_class;
        end else begin
          res_dropped = 1'b1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      notify      <= res_notify;
      notify_code <= res_code;
      event_count <= res_count;
      dropped     <= res_dropped;
    end
  end

endmodule
`default_nettype wire

[tb/tb_error_event_rate_limiter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb_error_event_rate_limiter: self-checking bench for the error rate limiter
// A directed table covers reset values, unknown, probe and gesture codes,
// the hold-off after a controller reset and the repeat window across the
// time wrap. Random phases then sweep the register settings, mixing
// advancing time with jumps and window-edge times. Every result is compared
// with its typed expectation, if any, or a cycle-free behavioural predictor.
// ----------------------------------------------------------------------------
module tb_error_event_rate_limiter;
  import eerl_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int LONG_STALL_CYCLES = 300;
  localparam int DRAIN_LIMIT       = 200000;

  typedef struct packed {
    logic               notify;
    logic [CLASS_W-1:0] cls;
    logic [COUNT_W-1:0] count;
    logic               dropped;
  } report_t;

  typedef struct packed {
    logic               counted;
    logic               holdoff;
    logic               escalate;
    logic [CLASS_W-1:0] warn_cls;
    logic [CLASS_W-1:0] err_cls;
  } code_props_t;

  typedef enum logic {ROW_EVENT, ROW_ENABLE} row_kind_e;
  typedef enum logic [1:0] {PRESSURE_NONE, PRESSURE_STALL_RX, PRESSURE_PAUSE_TX} pressure_e;

  typedef struct {
    row_kind_e         kind;
    logic [CODE_W-1:0] code;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] since;
    bit                typed;
    report_t           want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic [CODE_W-1:0] event_code;
  logic [TIME_W-1:0] now_ms;
  logic [TIME_W-1:0] ms_since_reset;
  logic out_valid;
  logic out_ready;
  logic notify;
  logic [CLASS_W-1:0] notify_code;
  logic [COUNT_W-1:0] event_count;
  logic dropped;

  // typed expectation travelling with the request on the input channel
  bit      typed_valid;
  report_t typed_report;

  // behavioural copy of the block state and registers
  logic               mdl_ready;
  logic [TIME_W-1:0]  mdl_window;
  logic [HOLD_W-1:0]  mdl_holdoff;
  logic [COUNT_W-1:0] code_count     [NUM_CODES_DEF];
  logic [TIME_W-1:0]  last_report_ms [NUM_CODES_DEF];

  report_t   pending_reports[$];
  stim_row_t directed_rows[$];
  int        fail_count = 0;

  int          send_idle_pct;
  int          recv_idle_pct;
  logic        rx_stall_req = 1'b0;
  logic [31:0] clk_ms;
  logic [31:0] up_ms;

  error_event_rate_limiter u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .event_code     (event_code),
    .now_ms         (now_ms),
    .ms_since_reset (ms_since_reset),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .notify         (notify),
    .notify_code    (notify_code),
    .event_count    (event_count),
    .dropped        (dropped)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("tb_error_event_rate_limiter NOT OK");
    $finish;
  end

  // per-code behaviour: counting, hold-off, escalation and classes
  function automatic code_props_t props_of(input logic [CODE_W-1:0] code);
    code_props_t p;
    p.counted  = !(code == EV_PROBE || code == EV_GESTURE);
    p.holdoff  = (code <= EV_CRC) || code == EV_HAL_CRASH || code == EV_SAVE_FULL;
    p.escalate = code == EV_I2C_RD_ERR || code == EV_I2C_WR_ERR || code == EV_SPI_RD_ERR ||
                 code == EV_SPI_WR_ERR || code == EV_ESD_ERR;
    case (code)
      EV_I2C_RD_ERR, EV_I2C_RD_WARN: p.warn_cls = CLS_I2C_RD_WARN;
      EV_I2C_WR_ERR, EV_I2C_WR_WARN: p.warn_cls = CLS_I2C_WR_WARN;
      EV_SPI_RD_ERR, EV_SPI_RD_WARN: p.warn_cls = CLS_SPI_RD_WARN;
      EV_SPI_WR_ERR, EV_SPI_WR_WARN: p.warn_cls = CLS_SPI_WR_WARN;
      EV_CRC:                        p.warn_cls = CLS_CRC;
      EV_FW_UPGRADE, EV_REQUEST_FW:  p.warn_cls = CLS_FW_UPGRADE;
      EV_ESD_ERR, EV_ESD_WARN:       p.warn_cls = CLS_ESD_WARN;
      EV_PROBE:                      p.warn_cls = CLS_ESD_ERR;
      EV_GESTURE:                    p.warn_cls = CLS_GESTURE;
      EV_GHOST:                      p.warn_cls = CLS_GHOST;
      EV_HAL_CRASH:                  p.warn_cls = CLS_HAL_CRASH;
      default:                       p.warn_cls = CLS_SAVE_FULL;
    endcase
    case (code)
      EV_I2C_RD_ERR: p.err_cls = CLS_I2C_RD_ERR;
      EV_I2C_WR_ERR: p.err_cls = CLS_I2C_WR_ERR;
      EV_SPI_RD_ERR: p.err_cls = CLS_SPI_RD_ERR;
      EV_SPI_WR_ERR: p.err_cls = CLS_SPI_WR_ERR;
      EV_ESD_ERR:    p.err_cls = CLS_ESD_ERR;
      default:       p.err_cls = p.warn_cls;
    endcase
    return p;
  endfunction

  // work out the report for one event and advance the code's state
  function automatic report_t predict_report(input logic [CODE_W-1:0] code,
                                             input logic [TIME_W-1:0] now,
                                             input logic [TIME_W-1:0] since);
    report_t            r;
    code_props_t        p;
    logic [COUNT_W-1:0] prev;
    logic [TIME_W-1:0]  age;
    logic               due;
    r = '0;
    p = props_of(code);
    if (!mdl_ready) begin
      r.dropped = 1'b1;
    end else if (code < KNOWN_CODES) begin
      if (!p.counted) begin
        r.notify = 1'b1;
        r.cls    = p.warn_cls;
      end else begin
        prev = code_count[code];
        age  = now - last_report_ms[code];
        due  = (prev == '0) || (age >= mdl_window);
        // saturate the count
        r.count = (prev == '1) ? prev : prev + 1'b1;
        code_count[code] = r.count;
        // hold bus and service codes off after a controller reset
        if (due && p.holdoff && since < {16'd0, mdl_holdoff})
          due = 1'b0;
        if (due) begin
          last_report_ms[code] = now;
          r.notify = 1'b1;
          r.cls = (p.escalate && (r.count % ESCALATE_PERIOD_DEF) == 0) ? p.err_cls : p.warn_cls;
        end else begin
          r.dropped = 1'b1;
        end
      end
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // monitor: registers, results and accepted requests, all sampled at the edge
  always @(posedge clk) begin
    report_t want;
    if (rst) begin
      mdl_ready   = 1'b0;
      mdl_window  = WINDOW_RST;
      mdl_holdoff = HOLD_RST;
      foreach (code_count[i]) begin
        code_count[i]     = '0;
        last_report_ms[i] = '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_READY:  mdl_ready   = cfg_data[0];
          REG_WINDOW: mdl_window  = cfg_data;
          REG_HOLD:   mdl_holdoff = cfg_data[HOLD_W-1:0];
          default:    ;  // out of range: ignore
        endcase
      end
      if (out_valid && out_ready) begin
        if (pending_reports.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          want = pending_reports.pop_front();
          check_field("notify", want.notify, notify);
          check_field("notify_code", want.cls, notify_code);
          check_field("event_count", want.count, event_count);
          check_field("dropped", want.dropped, dropped);
        end
      end
      if (in_valid && in_ready) begin
        want = predict_report(event_code, now_ms, ms_since_reset);
        pending_reports.push_back(typed_valid ? typed_report : want);
      end
    end
  end

  // receiver: random back-pressure, plus one long hold-off on request
  initial begin : rx_side
    int stall_left;
    bit stall_done;
    stall_left = 0;
    stall_done = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_stall_req && !stall_done) begin
        stall_left = LONG_STALL_CYCLES;
        stall_done = 1'b1;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  function automatic void add_row(input row_kind_e kind, input logic [CODE_W-1:0] code,
                                  input logic [TIME_W-1:0] now, input logic [TIME_W-1:0] since,
                                  input bit typed, input report_t want);
    stim_row_t row;
    row.kind  = kind;
    row.code  = code;
    row.now   = now;
    row.since = since;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endfunction

  // offer one request and hold it until accepted
  task automatic offer_event(input logic [CODE_W-1:0] code, input logic [TIME_W-1:0] now,
                             input logic [TIME_W-1:0] since, input bit typed,
                             input report_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    event_code     <= code;
    now_ms         <= now;
    ms_since_reset <= since;
    typed_valid    <= typed;
    typed_report   <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop sending and wait for every outstanding result; the extra edge lets
  // the monitor log a request accepted at the edge just passed
  task automatic drain_requests();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // write all registers back to back, plus the unused index
  task automatic load_setting(input logic [CFG_W-1:0] ready_word,
                              input logic [CFG_W-1:0] window_word,
                              input logic [CFG_W-1:0] hold_word);
    cfg_we    <= 1'b1;
    cfg_index <= REG_READY;
    cfg_data  <= ready_word;
    @(posedge clk);
    cfg_index <= REG_WINDOW;
    cfg_data  <= window_word;
    @(posedge clk);
    cfg_index <= REG_HOLD;
    cfg_data  <= hold_word;
    @(posedge clk);
    cfg_index <= REG_UNUSED;
    cfg_data  <= $urandom();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // one random phase under one register setting
  task automatic run_phase(input logic [CFG_W-1:0] ready_word, input logic [CFG_W-1:0] window_word,
                           input logic [CFG_W-1:0] hold_word, input int unsigned step_max,
                           input int send_pct, input int recv_pct, input int n_items,
                           input pressure_e pressure);
    logic [CODE_W-1:0] code;
    int unsigned       pick;
    int unsigned       hold_span;
    int                k;
    drain_requests();
    load_setting(ready_word, window_word, hold_word);
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
    if (pressure == PRESSURE_STALL_RX)
      rx_stall_req <= 1'b1;
    hold_span = 2 * hold_word[HOLD_W-1:0] + 2;
    for (k = 0; k < n_items; k++) begin
      if (pressure == PRESSURE_PAUSE_TX && k == n_items / 2)
        drain_requests();
      code = ($urandom_range(0, 99) < 8) ? CODE_W'($urandom_range(KNOWN_CODES, 31))
                                         : CODE_W'($urandom_range(0, KNOWN_CODES - 1));
      // advance time, jump now and then, or land on the window edge
      pick = $urandom_range(0, 99);
      if (pick < 6)
        clk_ms = $urandom();
      else if (pick < 12 && code < KNOWN_CODES)
        clk_ms = last_report_ms[code] + window_word - $urandom_range(0, 1);
      else if (pick < 85)
        clk_ms = clk_ms + $urandom_range(0, step_max);
      // controller resets drop the uptime below and around the hold-off
      pick = $urandom_range(0, 99);
      if (pick < 12)
        up_ms = $urandom_range(0, hold_span);
      else if (pick < 17)
        up_ms = $urandom();
      else
        up_ms = up_ms + $urandom_range(0, step_max);
      offer_event(code, clk_ms, up_ms, 1'b0, '0);
    end
  endtask

  // stimulus
  initial begin : tx_side
    int          wait_n;
    logic [31:0] window_rand;
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_index      <= '0;
    cfg_data       <= '0;
    in_valid       <= 1'b0;
    event_code     <= '0;
    now_ms         <= '0;
    ms_since_reset <= '0;
    typed_valid    <= 1'b0;
    typed_report   <= '0;
    send_idle_pct  = 35;
    recv_idle_pct  <= 79;
    clk_ms         = '0;
    up_ms          = '0;

    // reporting disabled after reset: everything dropped uncounted
    add_row(ROW_EVENT, EV_I2C_RD_ERR, '0, '0, 1'b1, '{1'b0, 4'd0, 32'd0, 1'b1});
    add_row(ROW_EVENT, 5'd31, '1, '1, 1'b1, '{1'b0, 4'd0, 32'd0, 1'b1});
    add_row(ROW_ENABLE, '0, '0, '0, 1'b0, '0);
    // unknown codes give an all-zero result
    add_row(ROW_EVENT, 5'd31, 32'd12345, 32'd1000, 1'b1, '0);
    add_row(ROW_EVENT, 5'd18, '1, '0, 1'b1, '0);
    // uncounted codes always report, and a first counted event reports too
    add_row(ROW_EVENT, EV_PROBE, 32'd7, '0, 1'b1, '{1'b1, CLS_ESD_ERR, 32'd0, 1'b0});
    add_row(ROW_EVENT, EV_GESTURE, 32'd7, '0, 1'b1, '{1'b1, CLS_GESTURE, 32'd0, 1'b0});
    add_row(ROW_EVENT, EV_REQUEST_FW, 32'd5, '0, 1'b1, '{1'b1, CLS_FW_UPGRADE, 32'd1, 1'b0});
    // held off just after a controller reset, then reported once the hold-off ends
    add_row(ROW_EVENT, EV_I2C_RD_ERR, 32'd100, 32'd0, 1'b1, '{1'b0, 4'd0, 32'd1, 1'b1});
    add_row(ROW_EVENT, EV_I2C_RD_ERR, 32'd100, 32'd199, 1'b1, '{1'b0, 4'd0, 32'd2, 1'b1});
    add_row(ROW_EVENT, EV_I2C_RD_ERR, '1, 32'd200, 1'b1,
            '{1'b1, CLS_I2C_RD_WARN, 32'd3, 1'b0});
    // window measured across the time wrap, one short then exactly on it
    add_row(ROW_EVENT, EV_I2C_RD_ERR, 32'd59998, '1, 1'b1, '{1'b0, 4'd0, 32'd4, 1'b1});
    add_row(ROW_EVENT, EV_I2C_RD_ERR, 32'd59999, '1, 1'b1,
            '{1'b1, CLS_I2C_RD_WARN, 32'd5, 1'b0});
    // remaining codes once each
    for (int c = EV_I2C_WR_ERR; c < KNOWN_CODES; c++) begin
      if (c != EV_PROBE && c != EV_GESTURE && c != EV_REQUEST_FW)
        add_row(ROW_EVENT, CODE_W'(c), 32'h8000_0000 + c, 32'hFFFF_FFFF - c, 1'b0, '0);
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_ENABLE) begin
        drain_requests();
        load_setting(32'hFFFF_FFFF, WINDOW_RST, {16'hFFFF, HOLD_RST});
      end else begin
        offer_event(directed_rows[i].code, directed_rows[i].now, directed_rows[i].since,
                    directed_rows[i].typed, directed_rows[i].want);
      end
    end

    window_rand = $urandom_range(1, 4000);
    run_phase(32'd1, 32'd1000, 32'd50, 600, 35, 79, 320, PRESSURE_NONE);
    run_phase(32'd1, 32'd0, 32'd0, 50, 35, 79, 280, PRESSURE_NONE);
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_FFFF, 1 << 24, 79, 35, 280,
              PRESSURE_NONE);
    run_phase(32'hFFFF_FFFE, 32'd30000, 32'hFFFF_03E8, 5000, 79, 35, 120, PRESSURE_NONE);
    run_phase(32'd1, window_rand, $urandom(), window_rand / 2 + 1, 0, 0, 400,
              PRESSURE_STALL_RX);
    run_phase(32'd1, WINDOW_RST, HOLD_RST, 25000, 0, 0, 400, PRESSURE_PAUSE_TX);

    // wait out the last results, then let the pipeline settle
    in_valid <= 1'b0;
    wait_n = 0;
    while (pending_reports.size() != 0 && wait_n < DRAIN_LIMIT) begin
      @(posedge clk);
      wait_n++;
    end
    repeat (8) @(posedge clk);
    if (pending_reports.size() != 0) begin
      $error("%0d expected results never arrived", pending_reports.size());
      fail_count++;
    end
    if (fail_count == 0)
      $display("tb_error_event_rate_limiter OK");
    else
      $display("tb_error_event_rate_limiter NOT OK");
    $finish;
  end

endmodule
`default_nettype wire

[error_event_rate_limiter.f]
src/eerl_pkg.sv
src/eerl_ram.sv
src/error_event_rate_limiter.sv
tb/tb_error_event_rate_limiter.sv
